@@ hdl/ljbc_pkg.sv @@
// Shared constants, codes and index helpers for the jitter buffer link controller.
`timescale 1ns / 1ps

package ljbc_pkg;

   localparam int SLOTS = 16;
   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam int ACT_W = 2;
   localparam int LEN_W = 11;
   localparam int STATUS_W = 8;
   localparam int MAC_W = 48;
   localparam int EVENT_W = 4;
   localparam int SLOT_W = 6;
   localparam int DROP_W = 32;
   localparam int FILL_W = 7;
   localparam int PREBUF_W = 7;
   localparam int TIMEOUT_W = 20;
   localparam int IDLE_W = 21;

   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 20;

   localparam logic [ACT_W-1:0] ACT_FRAME = 2'd0;
   localparam logic [ACT_W-1:0] ACT_PULL  = 2'd1;
   localparam logic [ACT_W-1:0] ACT_TICK  = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_AUDIO_LEN  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ACK_LEN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_LEGACY_LEN = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_SUCCESS    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_PREBUF     = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_TIMEOUT    = 3'd5;

   localparam logic [EVENT_W-1:0] EV_IGNORED   = 4'd0;
   localparam logic [EVENT_W-1:0] EV_NACK      = 4'd1;
   localparam logic [EVENT_W-1:0] EV_PAIRED    = 4'd2;
   localparam logic [EVENT_W-1:0] EV_SOFT_JOIN = 4'd3;
   localparam logic [EVENT_W-1:0] EV_STORED    = 4'd4;
   localparam logic [EVENT_W-1:0] EV_STORED_DROP = 4'd5;
   localparam logic [EVENT_W-1:0] EV_PLAY      = 4'd6;
   localparam logic [EVENT_W-1:0] EV_SILENCE   = 4'd7;
   localparam logic [EVENT_W-1:0] EV_WAIT      = 4'd8;
   localparam logic [EVENT_W-1:0] EV_TIMEOUT   = 4'd9;
   localparam logic [EVENT_W-1:0] EV_TICK      = 4'd10;

   localparam logic [LEN_W-1:0] AUDIO_LEN_RST = 11'd1440;
   localparam logic [LEN_W-1:0] ACK_LEN_RST = 11'd1;
   localparam logic [LEN_W-1:0] LEGACY_LEN_RST = 11'd4;
   localparam logic [STATUS_W-1:0] SUCCESS_RST = 8'd0;
   localparam logic [PREBUF_W-1:0] PREBUF_RST = 7'd3;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd2000;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] p);
      return (p == IDX_W'(SLOTS - 1)) ? '0 : p + 1'b1;
   endfunction

   function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] p,
                                                 input logic [CNT_W-1:0] c);
      logic [CNT_W:0] sum;
      sum = (CNT_W + 1)'(p) + (CNT_W + 1)'(c);
      if (sum >= (CNT_W + 1)'(SLOTS)) begin
         sum = sum - (CNT_W + 1)'(SLOTS);
      end
      return sum[IDX_W-1:0];
   endfunction

endpackage

@@ hdl/link_pairing_jitter_buffer_control_unit.sv @@
// Top level of the pairing and jitter buffer link controller.
`timescale 1ns / 1ps

// Link controller with a pairing mode and a playback mode.
// Items enter on req_*: an item is taken at a rising edge with start high and
// busy low. Each item gives exactly one result on rsp_*, shown for one cycle
// with rsp_valid high; the receiver cannot stall, so the result must be
// taken in that cycle. rsp_valid comes in the first cycle busy is low again.
// Items decided from the state alone end in the execute state; an audio
// store or a played slot also passes the slot state (a registered read of
// a slot list memory, then the write back); a pairing, a soft join or a
// timeout walks the n filled slots back to the free list one read and one
// write at a time.
// Free and filled slot lists live in two dual port synchronous memories
// read at their heads. After reset the free list is loaded with slots
// 0..SLOTS-1, one entry a cycle, while busy stays high.
// csr_* writes are taken at any edge with csr_we high; indexes beyond the
// register list are ignored. Write them only while the block is idle.
module link_pairing_jitter_buffer_control_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [ljbc_pkg::ACT_W-1:0]       req_action,
   input  logic [ljbc_pkg::LEN_W-1:0]       req_frame_length,
   input  logic [ljbc_pkg::STATUS_W-1:0]    req_status_byte,
   input  logic [ljbc_pkg::MAC_W-1:0]       req_source_mac,
   input  logic                             csr_we,
   input  logic [ljbc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [ljbc_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output logic                             rsp_valid,
   output logic [ljbc_pkg::EVENT_W-1:0]     rsp_event_res,
   output logic [ljbc_pkg::SLOT_W-1:0]      rsp_slot_index,
   output logic                             rsp_mode_now,
   output logic [ljbc_pkg::DROP_W-1:0]      rsp_drop_count,
   output logic [ljbc_pkg::FILL_W-1:0]      rsp_fill_level
);
   import ljbc_pkg::*;

   typedef enum logic [2:0] {
      ST_INIT, ST_IDLE, ST_EXEC, ST_SLOT, ST_FL_RD, ST_FL_WR
   } state_type;

   typedef enum logic [1:0] {
      K_STORE_FREE, K_STORE_OLD, K_PULL
   } kind_type;

   state_type state_ff;
   kind_type kind_ff;

   logic [LEN_W-1:0] audio_len_ff, ack_len_ff, legacy_len_ff;
   logic [STATUS_W-1:0] success_ff;
   logic [PREBUF_W-1:0] prebuf_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;

   logic [ACT_W-1:0] act_ff;
   logic [LEN_W-1:0] len_ff;
   logic [STATUS_W-1:0] status_ff;
   logic [MAC_W-1:0] mac_ff;

   logic mode_ff, peer_known_ff, primed_ff;
   logic [MAC_W-1:0] peer_ff;
   logic [DROP_W-1:0] drops_ff;
   logic [IDLE_W-1:0] idle_ff;
   logic [IDX_W-1:0] init_ff;

   logic [IDX_W-1:0] free_head_ff, filled_head_ff;
   logic [CNT_W-1:0] free_cnt_ff, filled_cnt_ff;

   logic rsp_valid_ff;
   logic [EVENT_W-1:0] rsp_event_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;

   logic [IDX_W-1:0] free_mem [SLOTS];
   logic [IDX_W-1:0] filled_mem [SLOTS];
   logic [IDX_W-1:0] free_rd_ff, filled_rd_ff;
   logic free_we, filled_we;
   logic [IDX_W-1:0] free_waddr, free_wdata, filled_waddr, filled_wdata;

   logic is_ack, is_audio, foreign;
   logic [IDLE_W-1:0] idle_inc;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         audio_len_ff  <= AUDIO_LEN_RST;
         ack_len_ff    <= ACK_LEN_RST;
         legacy_len_ff <= LEGACY_LEN_RST;
         success_ff    <= SUCCESS_RST;
         prebuf_ff     <= PREBUF_RST;
         timeout_ff    <= TIMEOUT_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_AUDIO_LEN:  audio_len_ff  <= csr_wdata[LEN_W-1:0];
            CSR_ACK_LEN:    ack_len_ff    <= csr_wdata[LEN_W-1:0];
            CSR_LEGACY_LEN: legacy_len_ff <= csr_wdata[LEN_W-1:0];
            CSR_SUCCESS:    success_ff    <= csr_wdata[STATUS_W-1:0];
            CSR_PREBUF:     prebuf_ff     <= csr_wdata[PREBUF_W-1:0];
            CSR_TIMEOUT:    timeout_ff    <= csr_wdata[TIMEOUT_W-1:0];
            default: ;
         endcase
      end
   end

   // slot list memories, read at the list heads every cycle
   always_ff @(posedge clock) begin
      if (free_we) begin
         free_mem[free_waddr] <= free_wdata;
      end
      free_rd_ff <= free_mem[free_head_ff];
   end

   always_ff @(posedge clock) begin
      if (filled_we) begin
         filled_mem[filled_waddr] <= filled_wdata;
      end
      filled_rd_ff <= filled_mem[filled_head_ff];
   end

   always_comb begin
      free_we = (state_ff == ST_INIT) || (state_ff == ST_FL_WR) ||
                (state_ff == ST_SLOT && kind_ff == K_PULL);
      free_waddr = (state_ff == ST_INIT) ? init_ff : wrap_add(free_head_ff, free_cnt_ff);
      free_wdata = (state_ff == ST_INIT) ? init_ff : filled_rd_ff;
      filled_we = (state_ff == ST_SLOT) && (kind_ff == K_STORE_FREE);
      filled_waddr = wrap_add(filled_head_ff, filled_cnt_ff);
      filled_wdata = free_rd_ff;
   end

   // frame classification on the captured item
   always_comb begin
      is_ack = !mode_ff && (len_ff >= ack_len_ff) &&
               ((len_ff == ack_len_ff) || (len_ff == legacy_len_ff));
      is_audio = !is_ack && (len_ff == audio_len_ff);
      foreign = peer_known_ff && (mac_ff != peer_ff);
      idle_inc = (idle_ff == '1) ? idle_ff : idle_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         init_ff        <= '0;
         mode_ff        <= 1'b0;
         peer_known_ff  <= 1'b0;
         peer_ff        <= '0;
         primed_ff      <= 1'b0;
         drops_ff       <= '0;
         idle_ff        <= '0;
         free_head_ff   <= '0;
         free_cnt_ff    <= CNT_W'(SLOTS);
         filled_head_ff <= '0;
         filled_cnt_ff  <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_INIT: begin
               init_ff <= init_ff + 1'b1;
               if (init_ff == IDX_W'(SLOTS - 1)) begin
                  state_ff <= ST_IDLE;
               end
            end
            ST_IDLE: begin
               if (start) begin
                  act_ff    <= req_action;
                  len_ff    <= req_frame_length;
                  status_ff <= req_status_byte;
                  mac_ff    <= req_source_mac;
                  state_ff  <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               rsp_slot_ff <= '0;
               priority if (act_ff == ACT_FRAME && is_ack && status_ff == success_ff) begin
                  peer_ff       <= mac_ff;
                  peer_known_ff <= 1'b1;
                  mode_ff       <= 1'b1;
                  drops_ff      <= '0;
                  primed_ff     <= 1'b0;
                  idle_ff       <= '0;
                  rsp_event_ff  <= EV_PAIRED;
                  rsp_valid_ff  <= (filled_cnt_ff == '0);
                  state_ff      <= (filled_cnt_ff == '0) ? ST_IDLE : ST_FL_RD;
               end else if (act_ff == ACT_FRAME && is_ack) begin
                  rsp_event_ff <= EV_NACK;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else if (act_ff == ACT_FRAME && is_audio && mode_ff) begin
                  idle_ff  <= '0;
                  kind_ff  <= (free_cnt_ff != '0) ? K_STORE_FREE : K_STORE_OLD;
                  state_ff <= ST_SLOT;
               end else if (act_ff == ACT_FRAME && is_audio && !foreign) begin
                  peer_ff       <= mac_ff;
                  peer_known_ff <= 1'b1;
                  mode_ff       <= 1'b1;
                  drops_ff      <= '0;
                  primed_ff     <= 1'b0;
                  idle_ff       <= '0;
                  rsp_event_ff  <= EV_SOFT_JOIN;
                  rsp_valid_ff  <= (filled_cnt_ff == '0);
                  state_ff      <= (filled_cnt_ff == '0) ? ST_IDLE : ST_FL_RD;
               end else if (act_ff == ACT_PULL && mode_ff && !primed_ff &&
                            (PREBUF_W'(filled_cnt_ff) < prebuf_ff)) begin
                  rsp_event_ff <= EV_WAIT;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else if (act_ff == ACT_PULL && mode_ff && filled_cnt_ff != '0) begin
                  primed_ff <= 1'b1;
                  kind_ff   <= K_PULL;
                  state_ff  <= ST_SLOT;
               end else if (act_ff == ACT_PULL && mode_ff) begin
                  primed_ff    <= 1'b1;
                  rsp_event_ff <= EV_SILENCE;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else if (act_ff == ACT_TICK && mode_ff &&
                            idle_inc > IDLE_W'(timeout_ff)) begin
                  idle_ff      <= idle_inc;
                  mode_ff      <= 1'b0;
                  primed_ff    <= 1'b0;
                  rsp_event_ff <= EV_TIMEOUT;
                  rsp_valid_ff <= (filled_cnt_ff == '0);
                  state_ff     <= (filled_cnt_ff == '0) ? ST_IDLE : ST_FL_RD;
               end else if (act_ff == ACT_TICK) begin
                  if (mode_ff) begin
                     idle_ff <= idle_inc;
                  end
                  rsp_event_ff <= EV_TICK;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  rsp_event_ff <= EV_IGNORED;
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_SLOT: begin
               unique case (kind_ff)
                  K_STORE_FREE: begin
                     free_head_ff  <= wrap_inc(free_head_ff);
                     free_cnt_ff   <= free_cnt_ff - 1'b1;
                     filled_cnt_ff <= filled_cnt_ff + 1'b1;
                     rsp_slot_ff   <= SLOT_W'(free_rd_ff);
                     rsp_event_ff  <= EV_STORED;
                  end
                  K_STORE_OLD: begin
                     // oldest slot goes straight back to the tail: same entry
                     filled_head_ff <= wrap_inc(filled_head_ff);
                     if (primed_ff && drops_ff != '1) begin
                        drops_ff <= drops_ff + 1'b1;
                     end
                     rsp_slot_ff  <= SLOT_W'(filled_rd_ff);
                     rsp_event_ff <= EV_STORED_DROP;
                  end
                  K_PULL: begin
                     filled_head_ff <= wrap_inc(filled_head_ff);
                     filled_cnt_ff  <= filled_cnt_ff - 1'b1;
                     free_cnt_ff    <= free_cnt_ff + 1'b1;
                     rsp_slot_ff    <= SLOT_W'(filled_rd_ff);
                     rsp_event_ff   <= EV_PLAY;
                  end
                  default: ;
               endcase
               rsp_valid_ff <= 1'b1;
               state_ff     <= ST_IDLE;
            end
            ST_FL_RD: begin
               state_ff <= ST_FL_WR;
            end
            ST_FL_WR: begin
               filled_head_ff <= wrap_inc(filled_head_ff);
               filled_cnt_ff  <= filled_cnt_ff - 1'b1;
               free_cnt_ff    <= free_cnt_ff + 1'b1;
               if (filled_cnt_ff == CNT_W'(1)) begin
                  rsp_valid_ff <= 1'b1;
                  state_ff     <= ST_IDLE;
               end else begin
                  state_ff <= ST_FL_RD;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy           = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_event_res  = rsp_event_ff;
   assign rsp_slot_index = rsp_slot_ff;
   assign rsp_mode_now   = mode_ff;
   assign rsp_drop_count = drops_ff;
   assign rsp_fill_level = FILL_W'(filled_cnt_ff);

endmodule

@@ hdl/ljbc_checker.sv @@
// Port-level assertions for the link controller, bound to the top level.
`timescale 1ns / 1ps

module ljbc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          start,
   input logic                          busy,
   input logic                          rsp_valid,
   input logic [ljbc_pkg::EVENT_W-1:0]  rsp_event_res,
   input logic                          rsp_mode_now,
   input logic [ljbc_pkg::FILL_W-1:0]   rsp_fill_level
);
   import ljbc_pkg::*;

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("accepted item did not raise busy");

   a_result_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result shown while busy");

   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_pairing_empty: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_mode_now |-> rsp_fill_level == '0)
      else $error("filled slots left in pairing mode");

   a_play_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_event_res == EV_PLAY || rsp_event_res == EV_STORED) |-> rsp_mode_now)
      else $error("slot event outside playback");

endmodule

bind link_pairing_jitter_buffer_control_unit ljbc_checker u_ljbc_checker (.*);

@@ verif/tb_top.sv @@
// Self-checking testbench for the link pairing jitter buffer controller.
`timescale 1ns / 1ps

module tb_top;
   import ljbc_pkg::*;

   localparam logic [ACT_W-1:0]     ACT_UNDEF     = 2'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE     = 3'd7;
   localparam logic                 MODE_PAIRING  = 1'b0;
   localparam logic                 MODE_PLAYBACK = 1'b1;
   localparam logic [MAC_W-1:0]     ALT_MAC       = 48'h02_00_5E_10_20_30;
   localparam int                   STALL_LIMIT   = 2000;

   typedef struct packed {
      logic [ACT_W-1:0]    action;
      logic [LEN_W-1:0]    frame_length;
      logic [STATUS_W-1:0] status_byte;
      logic [MAC_W-1:0]    source_mac;
   } link_req_type;

   typedef struct packed {
      logic [EVENT_W-1:0] event_res;
      logic [SLOT_W-1:0]  slot_index;
      logic               mode_now;
      logic [DROP_W-1:0]  drop_count;
      logic [FILL_W-1:0]  fill_level;
   } link_rsp_type;

   typedef struct packed {
      logic [LEN_W-1:0]     audio_len;
      logic [LEN_W-1:0]     ack_len;
      logic [LEN_W-1:0]     legacy_len;
      logic [STATUS_W-1:0]  success;
      logic [PREBUF_W-1:0]  prebuf;
      logic [TIMEOUT_W-1:0] timeout;
   } link_cfg_type;

   logic                  clock;
   logic                  reset = 1'b1;
   logic                  start = 1'b0;
   logic                  busy;
   logic [ACT_W-1:0]      req_action = '0;
   logic [LEN_W-1:0]      req_frame_length = '0;
   logic [STATUS_W-1:0]   req_status_byte = '0;
   logic [MAC_W-1:0]      req_source_mac = '0;
   logic                  csr_we = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;
   logic                  rsp_valid;
   logic [EVENT_W-1:0]    rsp_event_res;
   logic [SLOT_W-1:0]     rsp_slot_index;
   logic                  rsp_mode_now;
   logic [DROP_W-1:0]     rsp_drop_count;
   logic [FILL_W-1:0]     rsp_fill_level;

   link_pairing_jitter_buffer_control_unit i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_action       (req_action),
      .req_frame_length (req_frame_length),
      .req_status_byte  (req_status_byte),
      .req_source_mac   (req_source_mac),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .rsp_valid        (rsp_valid),
      .rsp_event_res    (rsp_event_res),
      .rsp_slot_index   (rsp_slot_index),
      .rsp_mode_now     (rsp_mode_now),
      .rsp_drop_count   (rsp_drop_count),
      .rsp_fill_level   (rsp_fill_level)
   );

   // predictor state
   link_cfg_type      link_cfg;
   logic              pair_mode;
   logic              peer_valid;
   logic [MAC_W-1:0]  peer_mac;
   logic              playback_primed;
   logic [DROP_W-1:0] drop_total;
   logic [IDLE_W-1:0] idle_run;
   logic [SLOT_W-1:0] free_slots[$];
   logic [SLOT_W-1:0] filled_slots[$];

   link_rsp_type link_events_due[$];
   int           link_errors = 0;
   int           quiet_cycles = 0;
   int           send_idle_pct = 0;

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic link_cfg_type link_settings(input int audio, ack, legacy, success,
                                                  input int prebuf, timeout);
      link_cfg_type c;
      c.audio_len  = LEN_W'(audio);
      c.ack_len    = LEN_W'(ack);
      c.legacy_len = LEN_W'(legacy);
      c.success    = STATUS_W'(success);
      c.prebuf     = PREBUF_W'(prebuf);
      c.timeout    = TIMEOUT_W'(timeout);
      return c;
   endfunction

   function automatic link_req_type req_of(input logic [ACT_W-1:0] action, input int len,
                                           input int status, input logic [MAC_W-1:0] mac);
      link_req_type it;
      it.action       = action;
      it.frame_length = LEN_W'(len);
      it.status_byte  = STATUS_W'(status);
      it.source_mac   = mac;
      return it;
   endfunction

   function automatic void flush_filled();
      while (filled_slots.size() != 0) begin
         free_slots.push_back(filled_slots.pop_front());
      end
   endfunction

   function automatic void enter_playback(input logic [MAC_W-1:0] mac);
      peer_mac        = mac;
      peer_valid      = 1'b1;
      pair_mode       = MODE_PLAYBACK;
      drop_total      = '0;
      playback_primed = 1'b0;
      idle_run        = '0;
      flush_filled();
   endfunction

   function automatic void reset_model();
      link_cfg = link_settings(AUDIO_LEN_RST, ACK_LEN_RST, LEGACY_LEN_RST, SUCCESS_RST,
                               PREBUF_RST, TIMEOUT_RST);
      pair_mode       = MODE_PAIRING;
      peer_valid      = 1'b0;
      peer_mac        = '0;
      playback_primed = 1'b0;
      drop_total      = '0;
      idle_run        = '0;
      free_slots      = {};
      filled_slots    = {};
      for (int i = 0; i < SLOTS; i++) begin
         free_slots.push_back(SLOT_W'(i));
      end
   endfunction

   function automatic link_rsp_type predict_link_event(input link_req_type it);
      link_rsp_type      r;
      logic [SLOT_W-1:0] s;
      r = '0;
      s = '0;
      r.event_res = EV_IGNORED;
      case (it.action)
         ACT_FRAME: begin
            // acknowledgement test wins over the audio length test
            if (pair_mode == MODE_PAIRING && it.frame_length >= link_cfg.ack_len &&
                (it.frame_length == link_cfg.ack_len ||
                 it.frame_length == link_cfg.legacy_len)) begin
               if (it.status_byte == link_cfg.success) begin
                  enter_playback(it.source_mac);
                  r.event_res = EV_PAIRED;
               end else begin
                  r.event_res = EV_NACK;
               end
            end else if (it.frame_length == link_cfg.audio_len) begin
               if (pair_mode == MODE_PLAYBACK) begin
                  idle_run = '0;
                  if (free_slots.size() != 0) begin
                     s = free_slots.pop_front();
                     r.event_res = EV_STORED;
                  end else if (filled_slots.size() != 0) begin
                     s = filled_slots.pop_front();
                     r.event_res = EV_STORED_DROP;
                     if (playback_primed && drop_total != '1) begin
                        drop_total = drop_total + 1'b1;
                     end
                  end
                  if (r.event_res != EV_IGNORED) begin
                     filled_slots.push_back(s);
                     r.slot_index = s;
                  end
               end else if (!(peer_valid && it.source_mac != peer_mac)) begin
                  enter_playback(it.source_mac);
                  r.event_res = EV_SOFT_JOIN;
               end
            end
         end
         ACT_PULL: begin
            if (pair_mode == MODE_PLAYBACK) begin
               if (!playback_primed && filled_slots.size() < int'(link_cfg.prebuf)) begin
                  r.event_res = EV_WAIT;
               end else begin
                  playback_primed = 1'b1;
                  if (filled_slots.size() != 0) begin
                     s = filled_slots.pop_front();
                     free_slots.push_back(s);
                     r.slot_index = s;
                     r.event_res = EV_PLAY;
                  end else begin
                     r.event_res = EV_SILENCE;
                  end
               end
            end
         end
         ACT_TICK: begin
            r.event_res = EV_TICK;
            if (pair_mode == MODE_PLAYBACK) begin
               if (idle_run != '1) begin
                  idle_run = idle_run + 1'b1;
               end
               if (idle_run > IDLE_W'(link_cfg.timeout)) begin
                  pair_mode       = MODE_PAIRING;
                  playback_primed = 1'b0;
                  flush_filled();
                  r.event_res = EV_TIMEOUT;
               end
            end
         end
         default: ;
      endcase
      r.mode_now   = pair_mode;
      r.drop_count = drop_total;
      r.fill_level = FILL_W'(filled_slots.size());
      return r;
   endfunction

   function automatic logic [MAC_W-1:0] pick_mac();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) begin
         return peer_mac;
      end else if (r < 75) begin
         return ALT_MAC;
      end
      return MAC_W'({$urandom, $urandom});
   endfunction

   // mostly well-formed traffic for the current mode, a little noise
   function automatic link_req_type pick_item(input int pull_pct, input int tick_pct);
      link_req_type it;
      int           r;
      r = $urandom_range(0, 99);
      it.action       = ACT_FRAME;
      it.frame_length = LEN_W'($urandom_range(0, 2047));
      it.status_byte  = STATUS_W'($urandom_range(0, 255));
      it.source_mac   = MAC_W'({$urandom, $urandom});
      if (r < 4) begin
         it.action = ACT_W'($urandom_range(0, 3));
      end else if (r < 4 + tick_pct) begin
         it.action = ACT_TICK;
      end else if (r < 4 + tick_pct + pull_pct) begin
         it.action = ACT_PULL;
      end else begin
         it.source_mac = pick_mac();
         if ((pair_mode == MODE_PAIRING && $urandom_range(0, 1) == 1) || r >= 96) begin
            it.frame_length = ($urandom_range(0, 1) == 1) ? link_cfg.ack_len
                                                          : link_cfg.legacy_len;
            if ($urandom_range(0, 3) != 0) begin
               it.status_byte = link_cfg.success;
            end
         end else begin
            it.frame_length = link_cfg.audio_len;
         end
      end
      return it;
   endfunction

   task automatic send_item(input link_req_type it);
      link_rsp_type due;
      if (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      start            <= 1'b1;
      req_action       <= it.action;
      req_frame_length <= it.frame_length;
      req_status_byte  <= it.status_byte;
      req_source_mac   <= it.source_mac;
      do @(posedge clock); while (busy !== 1'b0);
      due = predict_link_event(it);
      link_events_due.push_back(due);
   endtask

   task automatic wait_idle();
      start <= 1'b0;
      while (link_events_due.size() != 0 || busy !== 1'b0) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic apply_config(input link_cfg_type c);
      wait_idle();
      write_csr(CSR_AUDIO_LEN, CSR_DATA_W'(c.audio_len));
      write_csr(CSR_ACK_LEN, CSR_DATA_W'(c.ack_len));
      write_csr(CSR_LEGACY_LEN, CSR_DATA_W'(c.legacy_len));
      write_csr(CSR_SUCCESS, CSR_DATA_W'(c.success));
      write_csr(CSR_PREBUF, CSR_DATA_W'(c.prebuf));
      write_csr(CSR_TIMEOUT, CSR_DATA_W'(c.timeout));
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom));
      csr_we   <= 1'b0;
      link_cfg = c;
   endtask

   task automatic run_random(input link_cfg_type c, input int n, input int idle_pct,
                             input int pull_pct, input int tick_pct);
      apply_config(c);
      send_idle_pct = idle_pct;
      repeat (n) send_item(pick_item(pull_pct, tick_pct));
   endtask

   task automatic test_pairing_basics();
      send_idle_pct = 0;
      send_item(req_of(ACT_TICK, 0, 0, '0));
      send_item(req_of(ACT_PULL, 0, 0, '0));
      send_item(req_of(ACT_UNDEF, 2047, 255, '1));
      send_item(req_of(ACT_FRAME, 1, 8'h5A, ALT_MAC));
      send_item(req_of(ACT_FRAME, 4, 0, '1));
      send_item(req_of(ACT_PULL, 0, 0, '0));
      repeat (3) send_item(req_of(ACT_FRAME, 1440, 8'hC3, ALT_MAC));
      send_item(req_of(ACT_FRAME, 1, 0, '0));
      send_item(req_of(ACT_PULL, 2047, 255, '1));
      send_item(req_of(ACT_FRAME, 0, 0, '0));
   endtask

   task automatic test_timeout_rejoin();
      apply_config(link_settings(AUDIO_LEN_RST, ACK_LEN_RST, 0, SUCCESS_RST, 0, 1));
      send_idle_pct = 0;
      send_item(req_of(ACT_TICK, 0, 0, '0));
      send_item(req_of(ACT_TICK, 0, 0, '0));
      send_item(req_of(ACT_FRAME, 1440, 0, '0));
      send_item(req_of(ACT_FRAME, 0, 0, '1));
      send_item(req_of(ACT_FRAME, 1440, 255, '1));
      send_item(req_of(ACT_PULL, 0, 0, '0));
      send_item(req_of(ACT_FRAME, 1440, 0, ALT_MAC));
      send_item(req_of(ACT_PULL, 0, 0, '0));
      send_item(req_of(ACT_FRAME, 1, 0, '1));
   endtask

   task automatic test_traffic_soak();
      run_random(link_settings(1440, 1, 4, 0, 3, 6), 180, 0, 30, 15);
      run_random(link_settings(1440, 1, 4, 8'hA5, 1, 1), 180, 46, 35, 10);
      run_random(link_settings($urandom_range(1, 2047), $urandom_range(1, 2047),
                               $urandom_range(1, 2047), $urandom_range(0, 255),
                               $urandom_range(1, 20), $urandom_range(1, 30)),
                 180, 10, 30, 12);
   endtask

   task automatic test_length_extremes();
      run_random(link_settings(2047, 2047, 2047, 255, 64, 20'hFFFFF), 180, 0, 20, 10);
      run_random(link_settings(1, 0, 2047, 0, 0, 12), 180, 10, 30, 20);
      // audio length equal to the acknowledgement length
      run_random(link_settings(64, 64, 1, 8'h3C, 127, 3), 180, 46, 25, 25);
   endtask

   task automatic test_overrun_drops();
      run_random(link_settings($urandom_range(5, 2047), 3, 2, $urandom_range(0, 255),
                               16, 40), 180, 46, 10, 8);
      run_random(link_settings(700, 5, 9, 8'h11, 2, 60), 180, 0, 15, 5);
   endtask

   task automatic check_field(input string name, input logic [31:0] want, got);
      if (want !== got) begin
         $error("%s expected %0d got %0d", name, want, got);
         link_errors++;
      end
   endtask

   always @(posedge clock) begin
      link_rsp_type want;
      if (!reset && rsp_valid === 1'b1) begin
         if (link_events_due.size() == 0) begin
            $error("result with no item outstanding");
            link_errors++;
         end else begin
            want = link_events_due.pop_front();
            check_field("event_res", want.event_res, rsp_event_res);
            check_field("slot_index", want.slot_index, rsp_slot_index);
            check_field("mode_now", want.mode_now, rsp_mode_now);
            check_field("drop_count", want.drop_count, rsp_drop_count);
            check_field("fill_level", want.fill_level, rsp_fill_level);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && busy === 1'b0) || rsp_valid === 1'b1) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      reset_model();
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      do @(posedge clock); while (busy !== 1'b0);
      test_pairing_basics();
      test_timeout_rejoin();
      test_traffic_soak();
      test_length_extremes();
      test_overrun_drops();
      wait_idle();
      repeat (2 * SLOTS + 6) @(posedge clock);
      if (link_errors == 0 && link_events_due.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
